// ----- hw/rtl/bagi_pkg.sv -----
// ----------------------------------------------------------------------------
// bagi_pkg
// Types and constants for the binned average gap interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package bagi_pkg;

   localparam int NUM_BINS_DEFAULT = 64;
   localparam int SUM_W            = 48;
   localparam int CNT_W            = 16;
   localparam int ENTRY_W          = SUM_W + CNT_W;
   localparam int CSR_AW           = 3;
   localparam int DIV_W            = 56;

   localparam logic [CNT_W-1:0] COUNT_MAX       = 16'hFFFF;
   localparam logic             REG_BINS_IN_USE = 1'b0;
   localparam logic [6:0]       BINS_RESET      = 7'd64;

   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_FINALIZE = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] sample_value;
      logic [5:0]         bin_index;
   } req_type;

   typedef struct packed {
      logic [5:0]         out_bin;
      logic signed [31:0] bin_value;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/binned_average_gap_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// binned_average_gap_interpolator_top
// Per-bin sum and count in one memory; finalize averages, fills edges,
// interpolates interior gaps and reads every active bin out.
// ----------------------------------------------------------------------------
// Add: busy for a memory read, then a write back. Clear, ignored adds
// and the unused opcode leave the block idle.
// Finalize: averaging pass reads each bin and divides each bin with count above 1
// (serial divider); fill pass checks each bin, copies edge values and divides once per
// interpolated bin; readout reads each bin, one result strobe each.
// Results cannot be stalled. Synchronous reset clears all bins at once through
// per-entry valid bits and sets bins_in_use to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module binned_average_gap_interpolator_top #(
   parameter int NUM_BINS = bagi_pkg::NUM_BINS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire bagi_pkg::req_type           req_data,
   output logic                             rsp_valid,
   output bagi_pkg::rsp_type                rsp_data,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [bagi_pkg::CSR_AW-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import bagi_pkg::*;

   localparam int IW        = $clog2(NUM_BINS);
   localparam int CW        = $clog2(NUM_BINS + 1);
   localparam int DIV_STEPS = DIV_W;
   localparam int DCW       = $clog2(DIV_STEPS + 1);
   localparam logic [6:0]    NB_LIM = 7'(NUM_BINS);
   localparam logic [DCW-1:0] DIV_END = DCW'(DIV_STEPS);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b00000000001,
      S_ADD_RD   = 11'b00000000010,
      S_ADD_WR   = 11'b00000000100,
      S_AVG_RD   = 11'b00000001000,
      S_AVG_CHK  = 11'b00000010000,
      S_AVG_DIV  = 11'b00000100000,
      S_FILL     = 11'b00001000000,
      S_FILL_CHK = 11'b00010000000,
      S_GAP_DIV  = 11'b00100000000,
      S_OUT_RD   = 11'b01000000000,
      S_OUT_EMIT = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0]          bins_ff, bins_in;
   logic [NUM_BINS-1:0] valid_ff, valid_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                any_ff, any_in;
   logic [IW-1:0]       first_ff, first_in, last_ff, last_in;
   logic signed [SUM_W-1:0] first_val_ff, first_val_in, last_val_ff, last_val_in;
   logic [IW-1:0]       p_ff, p_in, j_ff, j_in;
   logic signed [SUM_W-1:0] pv_ff, pv_in, nv_ff, nv_in;
   logic signed [SUM_W:0]   diff_ff, diff_in;
   logic signed [DIV_W-1:0] prod_ff, prod_in;
   logic signed [31:0]  add_val_ff, add_val_in;
   logic [IW-1:0]       add_idx_ff, add_idx_in;
   logic [CNT_W-1:0]    div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [DIV_W-1:0]    div_quo_ff, div_quo_in;
   logic                div_neg_ff, div_neg_in;
   logic [DCW-1:0]      div_cnt_ff, div_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [ENTRY_W-1:0] mem [NUM_BINS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic               mem_we;
   logic [IW-1:0]      mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata;

   logic [CW-1:0]           nb, idx_nx;
   logic [IW-1:0]           icur, gap_len;
   logic signed [SUM_W-1:0] ent_sum;
   logic [CNT_W-1:0]        ent_cnt;
   logic [CNT_W:0]          rem_sh;
   logic                    div_ge, div_done, rec_en, adv1;
   logic signed [SUM_W-1:0] rec_val;
   logic signed [DIV_W-1:0] div_q, prod_nx;
   logic [SUM_W:0]          diff_nx;
   logic signed [SUM_W-1:0] sum_mag;

   always_comb begin
      if (bins_ff == 7'd0) begin
         nb = CW'(1);
      end else if (bins_ff > NB_LIM) begin
         nb = CW'(NUM_BINS);
      end else begin
         nb = bins_ff[CW-1:0];
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_BINS_IN_USE) ? {25'd0, bins_ff} : 32'd0;

   assign icur    = idx_ff[IW-1:0];
   assign idx_nx  = idx_ff + CW'(1);
   assign ent_sum = rd_vld_ff ? signed'(rd_data_ff[ENTRY_W-1:CNT_W]) : '0;
   assign ent_cnt = rd_vld_ff ? rd_data_ff[CNT_W-1:0] : '0;
   assign gap_len = icur - p_ff;
   assign sum_mag = ent_sum[SUM_W-1] ? -ent_sum : ent_sum;
   assign diff_nx = {ent_sum[SUM_W-1], ent_sum} - {pv_ff[SUM_W-1], pv_ff};
   assign prod_nx = prod_ff + {{(DIV_W-SUM_W-1){diff_ff[SUM_W]}}, diff_ff};

   assign rem_sh   = {div_rem_ff, div_quo_ff[DIV_W-1]};
   assign div_ge   = (rem_sh >= {1'b0, div_den_ff});
   assign div_done = (div_cnt_ff == DIV_END);
   assign div_q    = div_neg_ff ? -signed'(div_quo_ff) : signed'(div_quo_ff);

   always_comb begin
      state_in     = state_ff;
      bins_in      = bins_ff;
      valid_in     = valid_ff;
      idx_in       = idx_ff;
      any_in       = any_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      first_val_in = first_val_ff;
      last_val_in  = last_val_ff;
      p_in         = p_ff;
      j_in         = j_ff;
      pv_in        = pv_ff;
      nv_in        = nv_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      add_val_in   = add_val_ff;
      add_idx_in   = add_idx_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_quo_in   = div_quo_ff;
      div_neg_in   = div_neg_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = icur;
      mem_wdata    = '0;
      mem_raddr    = icur;
      rec_en       = 1'b0;
      rec_val      = ent_sum;
      adv1         = 1'b0;

      if (psel && penable && pwrite && (paddr[2] == REG_BINS_IN_USE)) begin
         bins_in = pwdata[6:0];
      end

      if ((state_ff == S_AVG_DIV || state_ff == S_GAP_DIV) && !div_done) begin
         div_rem_in = div_ge ? CNT_W'(rem_sh - {1'b0, div_den_ff}) : rem_sh[CNT_W-1:0];
         div_quo_in = {div_quo_ff[DIV_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff + DCW'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_data.opcode)
                  OP_ADD: begin
                     if ({1'b0, req_data.bin_index} < 7'(nb)) begin
                        add_val_in = req_data.sample_value;
                        add_idx_in = req_data.bin_index[IW-1:0];
                        state_in   = S_ADD_RD;
                     end
                  end
                  OP_FINALIZE: begin
                     idx_in   = '0;
                     any_in   = 1'b0;
                     state_in = S_AVG_RD;
                  end
                  OP_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            mem_raddr = add_idx_ff;
            state_in  = S_ADD_WR;
         end
         S_ADD_WR: begin
            if (ent_cnt != COUNT_MAX) begin
               mem_we    = 1'b1;
               mem_waddr = add_idx_ff;
               mem_wdata = {ent_sum + {{(SUM_W-32){add_val_ff[31]}}, add_val_ff},
                            ent_cnt + CNT_W'(1)};
            end
            state_in = S_IDLE;
         end
         S_AVG_RD: begin
            state_in = S_AVG_CHK;
         end
         S_AVG_CHK: begin
            if (rd_vld_ff && ent_cnt > CNT_W'(1)) begin
               div_neg_in = ent_sum[SUM_W-1];
               div_quo_in = {{(DIV_W-SUM_W){1'b0}}, sum_mag};
               div_den_in = ent_cnt;
               div_rem_in = '0;
               div_cnt_in = '0;
               state_in   = S_AVG_DIV;
            end else begin
               rec_en = rd_vld_ff;
               adv1   = 1'b1;
            end
         end
         S_AVG_DIV: begin
            if (div_done) begin
               mem_we    = 1'b1;
               mem_wdata = {div_q[SUM_W-1:0], CNT_W'(1)};
               rec_en    = 1'b1;
               rec_val   = div_q[SUM_W-1:0];
               adv1      = 1'b1;
            end
         end
         S_FILL: begin
            if (idx_ff == nb) begin
               idx_in   = '0;
               state_in = S_OUT_RD;
            end else if (icur < first_ff) begin
               mem_we    = 1'b1;
               mem_wdata = {first_val_ff, CNT_W'(1)};
               idx_in    = idx_nx;
            end else if (icur > last_ff) begin
               mem_we    = 1'b1;
               mem_wdata = {last_val_ff, CNT_W'(1)};
               idx_in    = idx_nx;
            end else if (icur == first_ff) begin
               p_in   = icur;
               pv_in  = first_val_ff;
               idx_in = idx_nx;
            end else if (valid_ff[icur]) begin
               state_in = S_FILL_CHK;
            end else begin
               idx_in = idx_nx;
            end
         end
         S_FILL_CHK: begin
            if (gap_len > IW'(1)) begin
               nv_in      = ent_sum;
               diff_in    = diff_nx;
               prod_in    = {{(DIV_W-SUM_W-1){diff_nx[SUM_W]}}, diff_nx};
               j_in       = p_ff + IW'(1);
               div_neg_in = diff_nx[SUM_W];
               div_quo_in = diff_nx[SUM_W] ?
                            DIV_W'(-signed'({{(DIV_W-SUM_W-1){diff_nx[SUM_W]}}, diff_nx})) :
                            {{(DIV_W-SUM_W-1){1'b0}}, diff_nx};
               div_den_in = {{(CNT_W-IW){1'b0}}, gap_len};
               div_rem_in = '0;
               div_cnt_in = '0;
               state_in   = S_GAP_DIV;
            end else begin
               p_in     = icur;
               pv_in    = ent_sum;
               idx_in   = idx_nx;
               state_in = S_FILL;
            end
         end
         S_GAP_DIV: begin
            if (div_done) begin
               mem_we    = 1'b1;
               mem_waddr = j_ff;
               mem_wdata = {pv_ff + div_q[SUM_W-1:0], CNT_W'(1)};
               if (j_ff + IW'(1) == icur) begin
                  p_in     = icur;
                  pv_in    = nv_ff;
                  idx_in   = idx_nx;
                  state_in = S_FILL;
               end else begin
                  j_in       = j_ff + IW'(1);
                  prod_in    = prod_nx;
                  div_neg_in = prod_nx[DIV_W-1];
                  div_quo_in = prod_nx[DIV_W-1] ? DIV_W'(-prod_nx) : DIV_W'(prod_nx);
                  div_rem_in = '0;
                  div_cnt_in = '0;
               end
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_EMIT;
         end
         S_OUT_EMIT: begin
            rsp_valid_in      = 1'b1;
            rsp_in.out_bin    = 6'(idx_ff);
            rsp_in.bin_value  = ent_sum[31:0];
            rsp_in.last       = (idx_nx == nb);
            idx_in            = idx_nx;
            state_in          = (idx_nx == nb) ? S_IDLE : S_OUT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rec_en) begin
         any_in      = 1'b1;
         first_in    = any_ff ? first_ff : icur;
         first_val_in = any_ff ? first_val_ff : rec_val;
         last_in     = icur;
         last_val_in = rec_val;
      end

      if (adv1) begin
         if (idx_nx == nb) begin
            idx_in   = '0;
            state_in = (any_ff || rec_en) ? S_FILL : S_OUT_RD;
         end else begin
            idx_in   = idx_nx;
            state_in = S_AVG_RD;
         end
      end

      if (mem_we) begin
         valid_in[mem_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
      rd_vld_ff  <= valid_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bins_ff      <= BINS_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         any_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bins_ff      <= bins_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         any_ff       <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      last_ff      <= last_in;
      first_val_ff <= first_val_in;
      last_val_ff  <= last_val_in;
      p_ff         <= p_in;
      j_ff         <= j_in;
      pv_ff        <= pv_in;
      nv_ff        <= nv_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      add_val_ff   <= add_val_in;
      add_idx_ff   <= add_idx_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      div_quo_ff   <= div_quo_in;
      div_neg_ff   <= div_neg_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_ff       <= rsp_in;
   end

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_OUT_EMIT))
      else $error("result strobe without readout");

   a_idle_only_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && rsp_valid_ff) |-> rsp_ff.last)
      else $error("readout ended before last bin");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("memory write while idle");

   a_gap_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GAP_DIV) |-> (j_ff > p_ff && j_ff < icur))
      else $error("interpolation index outside gap");

endmodule

`default_nettype wire
